// ===== rtl/gcd3_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd3_pkg
// Shared widths and controller/datapath interface types for the
// three-operand GCD block.
// ----------------------------------------------------------------------------
package gcd3_pkg;

  // operand width and shift counter width
  localparam int WIDTH   = 32;
  localparam int SHIFT_W = $clog2(WIDTH);

  // stream payload widths
  localparam int FIELD_W = 32;
  localparam int IN_W    = 3 * FIELD_W;
  localparam int OUT_W   = FIELD_W;

  typedef logic [WIDTH-1:0]   word_t;
  typedef logic [SHIFT_W-1:0] shift_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;    // take a new beat, start pair one
    logic strip;      // halve both, count a common factor of two
    logic reduce;     // one binary reduction step
    logic next_pair;  // start pair two from the pair-one result
    logic load_out;   // capture the final result
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic equal;      // working values equal: pair done
    logic both_even;  // common factor of two remains
  } sts_t;

endpackage

// ===== rtl/gcd_of_three.sv =====
// ----------------------------------------------------------------------------
// gcd_of_three
// Greatest common divisor of three unsigned operands, gcd(gcd(a,b),c),
// with a zero result when any operand is zero.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields (low bit up)                       beat
//  s_*      in   first_value, second_value, third_value    one operand set
//  m_*      out  divisor                                   one result
//
//  Each beat runs binary GCD twice on one shared subtract/shift datapath,
//  one step per cycle, at most 2*WIDTH-2 steps per pair. A zero operand
//  needs no reduction steps. The result sits in an output register, so the
//  core only holds when a finished result meets a full, stalled output.
//  Synchronous active-high reset clears control only.
// ----------------------------------------------------------------------------
module gcd_of_three (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [gcd3_pkg::IN_W-1:0]   s_tdata,   // first_value, second_value, third_value
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [gcd3_pkg::OUT_W-1:0]  m_tdata    // divisor
);
  import gcd3_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  gcd3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic
  gcd3_dp u_dp (
    .clk      (clk),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (m_tdata)
  );

endmodule

// ===== rtl/gcd3_dp.sv =====
// ----------------------------------------------------------------------------
// gcd3_dp
// Datapath: working registers for binary GCD, stored third operand,
// common power-of-two count and output register.
// ----------------------------------------------------------------------------
module gcd3_dp (
  input  logic                  clk,
  input  logic [gcd3_pkg::IN_W-1:0]  in_data,
  input  gcd3_pkg::cmd_t        cmd,
  output gcd3_pkg::sts_t        sts,
  output logic [gcd3_pkg::OUT_W-1:0] out_data
);
  import gcd3_pkg::*;

  word_t  x;
  word_t  y;
  word_t  third;
  shift_t k;
  word_t  op_a;
  word_t  op_b;
  word_t  op_c;
  logic   any_zero;
  word_t  pair_result;
  word_t  diff_xy;
  word_t  diff_yx;

  // operand unpacking, first field in the low bits
  assign op_a = WIDTH'(in_data[FIELD_W-1:0]);
  assign op_b = WIDTH'(in_data[2*FIELD_W-1:FIELD_W]);
  assign op_c = WIDTH'(in_data[3*FIELD_W-1:2*FIELD_W]);
  assign any_zero = (op_a == '0) || (op_b == '0) || (op_c == '0);

  // pair result restores the common power of two
  assign pair_result = x << k;
  assign diff_xy     = x - y;
  assign diff_yx     = y - x;

  // status
  assign sts.equal     = (x == y);
  assign sts.both_even = !x[0] && !y[0];

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      // a zero anywhere forces all zeros, which finish at once as zero
      x     <= any_zero ? '0 : op_a;
      y     <= any_zero ? '0 : op_b;
      third <= any_zero ? '0 : op_c;
      k     <= '0;
    end else if (cmd.next_pair) begin
      x <= pair_result;
      y <= third;
      k <= '0;
    end else if (cmd.strip) begin
      x <= x >> 1;
      y <= y >> 1;
      k <= k + shift_t'(1);
    end else if (cmd.reduce) begin
      if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x >= y) begin
        x <= diff_xy >> 1;
      end else begin
        y <= diff_yx >> 1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= OUT_W'(pair_result);
    end
  end

endmodule

// ===== rtl/gcd3_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcd3_ctrl
// Controller: sequences the two pairwise GCD runs and owns the stream
// handshakes and the output valid flag.
// ----------------------------------------------------------------------------
module gcd3_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  gcd3_pkg::sts_t sts,
  output gcd3_pkg::cmd_t cmd
);
  import gcd3_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIP,
    ST_REDUCE,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   pass;
  logic   pass_next;
  logic   m_tvalid_next;
  logic   slot_free;

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  // next state and commands
  always_comb begin
    state_next    = state;
    pass_next     = pass;
    m_tvalid_next = m_tvalid && !m_tready;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          pass_next   = 1'b0;
          state_next  = ST_STRIP;
        end
      end
      ST_STRIP, ST_REDUCE: begin
        if (sts.equal) begin
          if (!pass) begin
            cmd.next_pair = 1'b1;
            pass_next     = 1'b1;
            state_next    = ST_STRIP;
          end else begin
            state_next = ST_DONE;
          end
        end else if (state == ST_STRIP && sts.both_even) begin
          cmd.strip = 1'b1;
        end else begin
          cmd.reduce = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_DONE: begin
        // wait until the output register is free or being drained
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pass     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      pass     <= pass_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ===== bench/tb_gcd_of_three.sv =====
// ----------------------------------------------------------------------------
// tb_gcd_of_three
// Stream-level test of the three-operand GCD block. Operand beats go in on
// the slave side with random gaps. Results come out on the master side with
// random back-pressure. Each accepted beat is scored against a
// remainder-based GCD with the zero-operand rule, in arrival order.
// ----------------------------------------------------------------------------
module tb_gcd_of_three;
  timeunit 1ns;
  timeprecision 1ps;

  import gcd3_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES   = 200;   // quiet time after the last result

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;   // first_value, second_value, third_value
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;         // divisor

  logic [OUT_W-1:0] divisor_q[$];    // divisors still owed by the block
  int               error_count = 0;
  int               quiet_cycles = 0;
  int               stall_left   = 0;
  bit               jitter_on    = 1'b1;  // random gaps and back-pressure

  gcd_of_three dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // GCD prediction
  // --------------------------------------------------------------------------

  // Euclid by remainders, zero if either side is zero
  function automatic word_t pair_gcd(word_t x, word_t y);
    word_t r;
    if (x == '0 || y == '0) begin
      return '0;
    end
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic logic [OUT_W-1:0] gcd_three(word_t a, word_t b, word_t c);
    return OUT_W'(pair_gcd(pair_gcd(a, b), c));
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: log accepted operands, check returned divisors
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        divisor_q.push_back(gcd_three(word_t'(s_tdata[0*FIELD_W +: FIELD_W]),
                                      word_t'(s_tdata[1*FIELD_W +: FIELD_W]),
                                      word_t'(s_tdata[2*FIELD_W +: FIELD_W])));
      end
      if (m_tvalid && m_tready) begin
        if (divisor_q.size() == 0) begin
          $error("divisor: unexpected beat, actual %0h", m_tdata);
          error_count++;
        end else begin
          want = divisor_q.pop_front();
          if (m_tdata !== want) begin
            $error("divisor: expected %0h, actual %0h", want, m_tdata);
            error_count++;
          end
        end
      end
    end
  end

  // Output back-pressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (jitter_on && m_tready && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** gcd_of_three: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one operand beat and hold it until accepted
  task automatic send_operands(input word_t a, input word_t b, input word_t c);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    do @(posedge clk); while (!s_tready);
  endtask

  // Step past the current edge so its scoreboard update is in, then wait
  task automatic wait_results_drained();
    @(posedge clk);
    while (divisor_q.size() != 0) @(posedge clk);
  endtask

  // Random operand of random magnitude so short and full-width values both show up
  function automatic word_t rand_operand();
    word_t v;
    v = word_t'($urandom);
    case ($urandom_range(0, 3))
      0: v = v & word_t'(32'hFF);
      1: v = v & word_t'(32'hFFFF);
      default: ;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, zero rule, equal operands, powers of two, coprime values
  task automatic test_directed();
    send_operands('0, '0, '0);
    send_operands('0, 32'd12, 32'd18);
    send_operands(32'd12, '0, 32'd18);
    send_operands(32'd12, 32'd18, '0);
    send_operands('1, '0, '1);
    send_operands('1, '1, '1);
    send_operands(32'd1, 32'd1, 32'd1);
    send_operands(32'd1, '1, 32'h8000_0000);
    send_operands(32'd77, 32'd77, 32'd77);
    send_operands(32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
    send_operands(32'h8000_0000, 32'h4000_0000, 32'h2000_0000);
    send_operands(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_operands(32'd12, 32'd18, 32'd30);
    send_operands(32'd17, 32'd19, 32'd23);
    send_operands('1, 32'h5555_5555, 32'h3333_3333);
    send_operands(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'd2);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555, '1);
    send_operands(32'd1, 32'd2, 32'd3);
    send_operands(32'hFFFF_0000, 32'h0000_FFFF, 32'h00FF_FF00);
    send_operands(32'd6, 32'hC000_0000, 32'd48);
  endtask

  // Five beats, then the sender holds off until every result is back
  task automatic test_drain_pause();
    repeat (5) send_operands(rand_operand(), rand_operand(), rand_operand());
    s_tvalid <= 1'b0;
    wait_results_drained();
  endtask

  // Mostly operand sets built on a shared factor, some plain random, some zeros
  task automatic test_random(input int count);
    word_t g, a, b, c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = word_t'($urandom);
          b = word_t'($urandom);
          c = word_t'($urandom);
        end
        3: begin
          // zero lands in one random slot
          a = rand_operand();
          b = rand_operand();
          c = rand_operand();
          case ($urandom_range(0, 2))
            0: a = '0;
            1: b = '0;
            default: c = '0;
          endcase
        end
        default: begin
          // common factor, sometimes with extra powers of two
          g = word_t'($urandom_range(1, 65535));
          if ($urandom_range(0, 1) == 0) begin
            g = g << $urandom_range(0, 15);
          end
          a = g * word_t'($urandom_range(1, 32'hFFFF_FFFF / g));
          b = g * word_t'($urandom_range(1, 32'hFFFF_FFFF / g));
          c = g * word_t'($urandom_range(1, 32'hFFFF_FFFF / g));
        end
      endcase
      send_operands(a, b, c);
    end
  endtask

  // Back-to-back beats with a ready sink
  task automatic test_streaming(input int count);
    jitter_on = 1'b0;
    test_random(count);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_drain_pause();
    test_random(600);
    test_drain_pause();
    test_streaming(80);

    s_tvalid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** gcd_of_three: PASSED **");
    end else begin
      $display("** gcd_of_three: FAILED **");
    end
    $finish;
  end

endmodule
